FILE: rtl/ctcgd_pkg.sv
// Shared constants, types and the exp(-k/64) ROM contents for the greedy CTC decoder.
// No dependencies.
package ctcgd_pkg;

	localparam int CLASS_CAP       = 8192;
	localparam int EXP_TABLE_DEPTH = 1024;
	localparam int CLS_W           = $clog2(CLASS_CAP);
	localparam int EXP_AW          = $clog2(EXP_TABLE_DEPTH);
	localparam int IDX_W           = 13;
	localparam int LBL_W           = 14;
	localparam int FIFO_DEPTH      = 2;
	localparam int FIFO_AW         = $clog2(FIFO_DEPTH);
	localparam int CFG_IDX_W       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PROB_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LABEL_COUNT = 2'd1;

	localparam logic [LBL_W-1:0] NONE_MARK     = '1;
	localparam logic [LBL_W-1:0] LABEL_RST     = 14'd8192;
	localparam logic [31:0]      ONE_Q16       = 32'd65536;
	localparam logic [63:0]      EXP_STEP_Q32  = 64'd4228380000;

	localparam logic KIND_CHAR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic [15:0] exp_tab_t [EXP_TABLE_DEPTH];

	typedef struct packed {
		logic [CLS_W-1:0]  best_index;
		logic [15:0]       best_score;
		logic [31:0]       exp_sum;
		logic              prob_mode;
		logic [LBL_W-1:0]  label_count;
		logic              frame_last;
	} frame_t;

	function automatic exp_tab_t build_exp_table();
		exp_tab_t     t;
		logic [63:0]  x;
		logic [63:0]  v;
		logic [127:0] p;
		x = 64'd1 << 32;
		for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
			v = (x + 64'd32768) >> 16;
			t[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
			p = {64'd0, x} * {64'd0, EXP_STEP_Q32} + 128'd2147483648;
			x = p[95:32];
		end
		return t;
	endfunction

	localparam exp_tab_t EXP_TABLE = build_exp_table();

	function automatic logic [15:0] sat16(input logic [32:0] q);
		return (|q[32:16]) ? 16'hFFFF : q[15:0];
	endfunction

endpackage

FILE: rtl/ctcgd_if.sv
// Channel interfaces: score input, result output and register write port.
// No dependencies.
interface ctcgd_in_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] score;
	logic              class_last;
	logic              frame_last;
	modport source (output valid, score, class_last, frame_last, input ready);
	modport sink (input valid, score, class_last, frame_last, output ready);
endinterface

interface ctcgd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [12:0] char_index;
	logic [15:0] confidence;
	logic [15:0] char_count;
	logic        last;
	modport source (output valid, kind, char_index, confidence, char_count, last, input ready);
	modport sink (input valid, kind, char_index, confidence, char_count, last, output ready);
endinterface

interface ctcgd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [13:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/ctcgd_fifo.sv
// Two-entry frame queue between the score front end and the decision back end.
// Depends on ctcgd_pkg.
module ctcgd_fifo import ctcgd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t push_data,
	output logic   full,
	input  logic   pop,
	output frame_t pop_data,
	output logic   empty
);
	frame_t             mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full     = cnt_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty    = cnt_q == '0;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

FILE: rtl/ctcgd_front.sv
// Front end: takes scores, keeps the running argmax and the online softmax sum,
// holds the registers and queues one record per frame. Depends on ctcgd_pkg.
module ctcgd_front import ctcgd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ctcgd_in_if.sink   scores,
	ctcgd_cfg_if.sink  cfg,
	output logic   push,
	output frame_t push_data,
	input  logic   full
);
	logic              prob_q;
	logic [LBL_W-1:0]  label_q;
	logic              phase_q;
	logic [CLS_W-1:0]  cnt_q;
	logic [CLS_W-1:0]  best_idx_q;
	logic signed [15:0] best_q;
	logic [31:0]       sum_q;

	logic signed [15:0] score_s1;
	logic              cl_s1, fl_s1, first_s1, rise_s1, over_s1;
	logic [15:0]       rom_s1;

	logic              first, gt;
	logic signed [16:0] diff;
	logic [13:0]       d_idx;

	logic [15:0]       e;
	logic [47:0]       prod;
	logic [32:0]       rise_sum;
	logic [32:0]       add_sum;
	logic [31:0]       sum_n;
	logic signed [15:0] best_n;
	logic [CLS_W-1:0]  idx_n;

	assign cfg.ready    = 1'b1;
	assign scores.ready = !phase_q && !full;

	always_comb begin
		first = cnt_q == '0;
		gt    = scores.score > best_q;
		diff  = gt ? (17'(scores.score) - 17'(best_q)) : (17'(best_q) - 17'(scores.score));
		d_idx = diff[15:2];
	end

	always_comb begin
		e        = over_s1 ? 16'd0 : rom_s1;
		prod     = {16'd0, sum_q} * {32'd0, e};
		rise_sum = 33'(((prod + 48'd32768) >> 16)) + {1'b0, ONE_Q16};
		add_sum  = {1'b0, sum_q} + {17'd0, e};
		if (first_s1) begin
			sum_n  = ONE_Q16;
			best_n = score_s1;
			idx_n  = '0;
		end else if (rise_s1) begin
			sum_n  = rise_sum[32] ? 32'hFFFF_FFFF : rise_sum[31:0];
			best_n = score_s1;
			idx_n  = cnt_q;
		end else begin
			sum_n  = add_sum[32] ? 32'hFFFF_FFFF : add_sum[31:0];
			best_n = best_q;
			idx_n  = best_idx_q;
		end
		push                  = phase_q && cl_s1;
		push_data.best_index  = idx_n;
		push_data.best_score  = best_n;
		push_data.exp_sum     = sum_n;
		push_data.prob_mode   = prob_q;
		push_data.label_count = label_q;
		push_data.frame_last  = fl_s1;
	end

	always_ff @(posedge clk) begin
		if (scores.valid && scores.ready) begin
			score_s1 <= scores.score;
			cl_s1    <= scores.class_last;
			fl_s1    <= scores.frame_last;
			first_s1 <= first;
			rise_s1  <= !first && gt;
			over_s1  <= d_idx >= 14'(EXP_TABLE_DEPTH);
			rom_s1   <= EXP_TABLE[d_idx[EXP_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prob_q     <= 1'b0;
			label_q    <= LABEL_RST;
			phase_q    <= 1'b0;
			cnt_q      <= '0;
			best_idx_q <= '0;
			best_q     <= '0;
			sum_q      <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == REG_PROB_MODE) prob_q <= cfg.data[0];
				else if (cfg.index == REG_LABEL_COUNT) label_q <= cfg.data;
			end
			if (!phase_q) begin
				if (scores.valid && scores.ready) phase_q <= 1'b1;
			end else begin
				phase_q    <= 1'b0;
				sum_q      <= sum_n;
				best_q     <= best_n;
				best_idx_q <= idx_n;
				if (cl_s1) cnt_q <= '0;
				else if (cnt_q != CLS_W'(CLASS_CAP - 1)) cnt_q <= cnt_q + 1'b1;
			end
		end
	end
endmodule

FILE: rtl/ctcgd_div.sv
// Restoring divider, one quotient bit per cycle, 33-bit by 32-bit.
// Depends on ctcgd_pkg.
module ctcgd_div import ctcgd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [32:0] quotient
);
	logic [31:0] rem_q, dvs_q;
	logic [32:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] sh, sub;
	logic        ge;

	assign sh       = {rem_q, quo_q[32]};
	assign ge       = sh >= {1'b0, dvs_q};
	assign sub      = sh - {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? sub[31:0] : sh[31:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end
endmodule

FILE: rtl/ctcgd_back.sv
// Back end: frame confidence, keep decision, line statistics and the result register.
// Depends on ctcgd_pkg and ctcgd_div.
module ctcgd_back import ctcgd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  frame_t frame,
	output logic   pop,
	ctcgd_out_if.source results
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;
	localparam logic [2:0] S_EMIT = 3'd2;
	localparam logic [2:0] S_MEAN = 3'd3;
	localparam logic [2:0] S_DIV2 = 3'd4;
	localparam logic [2:0] S_SUMO = 3'd5;
	localparam logic [2:0] S_PROB = 3'd6;

	logic [2:0]        state_q;
	frame_t            fr_q;
	logic [15:0]       conf_q;
	logic [LBL_W-1:0]  prev_q;
	logic [31:0]       csum_q;
	logic [15:0]       kept_q;

	logic              out_valid_q, kind_q, last_q;
	logic [IDX_W-1:0]  idx_q;
	logic [15:0]       oconf_q, ocnt_q;

	logic              div_start, div_done;
	logic [32:0]       div_a, div_q;
	logic [31:0]       div_b;
	logic              slot, keep;
	logic [15:0]       prob_conf;
	logic [15:0]       kept_n;
	logic [32:0]       csum_add;

	assign results.valid      = out_valid_q;
	assign results.kind       = kind_q;
	assign results.char_index = idx_q;
	assign results.confidence = oconf_q;
	assign results.char_count = ocnt_q;
	assign results.last       = last_q;

	assign slot = !out_valid_q || results.ready;
	assign pop  = state_q == S_IDLE && !empty;

	always_comb begin
		prob_conf = fr_q.best_score[15] ? 16'd0
			: (|fr_q.best_score[14:8]) ? 16'hFFFF : {fr_q.best_score[7:0], 8'd0};
		keep = fr_q.best_index != '0
			&& {1'b0, fr_q.best_index} != prev_q
			&& {1'b0, fr_q.best_index} < fr_q.label_count;
		kept_n   = (kept_q == 16'hFFFF) ? kept_q : kept_q + 1'b1;
		csum_add = {1'b0, csum_q} + {17'd0, conf_q};
		div_start = 1'b0;
		div_a     = {1'b1, 32'd0};
		div_b     = frame.exp_sum;
		if (pop && !frame.prob_mode && frame.exp_sum != '0) div_start = 1'b1;
		if (state_q == S_MEAN && kept_q != '0) begin
			div_start = 1'b1;
			div_a     = {1'b0, csum_q};
			div_b     = {16'd0, kept_q};
		end
	end

	ctcgd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk) begin
		if (pop) fr_q <= frame;
		if (pop) conf_q <= 16'd0;
		if (state_q == S_DIV1 && div_done) conf_q <= sat16(div_q);
		if (state_q == S_PROB) conf_q <= prob_conf;
		if (state_q == S_MEAN && kept_q == '0) conf_q <= 16'd0;
		if (state_q == S_DIV2 && div_done) conf_q <= sat16(div_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= NONE_MARK;
			csum_q      <= '0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= KIND_CHAR;
			last_q      <= 1'b0;
			idx_q       <= '0;
			oconf_q     <= '0;
			ocnt_q      <= '0;
		end else begin
			if (results.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (frame.prob_mode) state_q <= S_PROB;
						else if (frame.exp_sum != '0) state_q <= S_DIV1;
						else state_q <= S_EMIT;
					end
				end
				S_PROB: begin
					state_q <= S_EMIT;
				end
				S_DIV1: begin
					if (div_done) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot) begin
						if (keep) begin
							out_valid_q <= 1'b1;
							kind_q      <= KIND_CHAR;
							last_q      <= 1'b0;
							idx_q       <= IDX_W'(fr_q.best_index);
							oconf_q     <= conf_q;
							ocnt_q      <= kept_n;
							kept_q      <= kept_n;
							csum_q      <= csum_add[32] ? 32'hFFFF_FFFF : csum_add[31:0];
						end
						prev_q  <= {1'b0, fr_q.best_index};
						state_q <= fr_q.frame_last ? S_MEAN : S_IDLE;
					end
				end
				S_MEAN: begin
					state_q <= (kept_q != '0) ? S_DIV2 : S_SUMO;
				end
				S_DIV2: begin
					if (div_done) state_q <= S_SUMO;
				end
				S_SUMO: begin
					if (slot) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_SUMMARY;
						last_q      <= 1'b1;
						idx_q       <= '0;
						oconf_q     <= conf_q;
						ocnt_q      <= kept_q;
						prev_q      <= NONE_MARK;
						csum_q      <= '0;
						kept_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/ctc_greedy_decoder_top.sv
// Greedy CTC decoder top level: front end, frame queue, back end.
// Each score gets a table read, then a sum update, before the next score is accepted.
// Frame end: outside prob_mode the back end runs the 33-step confidence divide,
// overlapped with the next frame's scores; line end adds a divide for the mean.
// Reset (arst_n low) clears all control state; label_count returns to 8192,
// prob_mode to 0 and the previous argmax to the none marker.
module ctc_greedy_decoder_top import ctcgd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ctcgd_in_if.sink    scores,
	ctcgd_out_if.source results,
	ctcgd_cfg_if.sink   cfg
);
	logic   push, full, pop, empty;
	frame_t push_data, pop_data;

	ctcgd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.scores    (scores),
		.cfg       (cfg),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	ctcgd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	ctcgd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.empty   (empty),
		.frame   (pop_data),
		.pop     (pop),
		.results (results)
	);
endmodule

FILE: rtl/ctcgd_checker.sv
// Port-level checks on the decoder's result channel, bound to the top level.
// Depends on ctcgd_pkg.
module ctcgd_checker import ctcgd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic        kind,
	input logic [12:0] char_index,
	input logic [15:0] char_count,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(char_index) && $stable(kind))
		else $error("result beat changed while stalled");

	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> last == kind)
		else $error("last and kind disagree");

	a_sum_idx: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_SUMMARY |-> char_index == '0)
		else $error("summary with nonzero index");

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		valid && kind == KIND_CHAR |-> char_index != '0 && char_count != '0)
		else $error("character beat with blank index or zero count");
endmodule

bind ctc_greedy_decoder_top ctcgd_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (results.valid),
	.ready      (results.ready),
	.kind       (results.kind),
	.char_index (results.char_index),
	.char_count (results.char_count),
	.last       (results.last)
);
